[rtl/core/rtlpm_pkg.sv]
`timescale 1ns / 1ps
package rtlpm_pkg;

  // request codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_DEL    = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOROUTE = 2'd2;

  typedef struct packed {
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [3:0]  iface;
  } route_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, rewind slot counter
    logic step;      // advance slot counter (add search)
    logic add_wr;    // write route to current slot
    logic add_full;  // report table full
    logic scan;      // read current slot, advance counter
  } rtlpm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] act;
    logic       ifc_ok;
    logic       cur_free;
    logic       last;
  } rtlpm_sts_t;

endpackage

[rtl/core/rtlpm_ctrl.sv]
`timescale 1ns / 1ps
module rtlpm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rtlpm_pkg::rtlpm_sts_t sts,
  output rtlpm_pkg::rtlpm_cmd_t cmd,
  output logic                busy,
  output logic                resp_valid
);
  import rtlpm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_ADD      = 6'b000100,
    S_SCAN     = 6'b001000,
    S_DRAIN    = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.act)
          ACT_ADD: begin
            if (sts.ifc_ok) begin
              state_nxt = S_ADD;
            end else begin
              cmd.add_full = 1'b1;
              state_nxt    = S_RESP;
            end
          end
          ACT_DEL:    state_nxt = sts.ifc_ok ? S_SCAN : S_RESP;
          ACT_LOOKUP: state_nxt = S_SCAN;
          default:    state_nxt = S_RESP;
        endcase
      end
      S_ADD: begin
        if (sts.cur_free) begin
          cmd.add_wr = 1'b1;
          state_nxt  = S_RESP;
        end else if (sts.last) begin
          cmd.add_full = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_RESP;
      S_RESP:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign resp_valid = (state_r == S_RESP);

  a_resp_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP |=> state_r == S_IDLE)
    else $error("result strobe held longer than one cycle");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_DISPATCH)
    else $error("accepted request not dispatched");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && sts.last |=> state_r == S_DRAIN)
    else $error("scan ran past last slot");

endmodule

[rtl/core/rtlpm_dp.sv]
`timescale 1ns / 1ps
module rtlpm_dp #(
  parameter int ROUTE_SLOTS = 8,
  parameter int IFACE_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtlpm_pkg::rtlpm_cmd_t cmd,
  output rtlpm_pkg::rtlpm_sts_t sts,
  input  logic [1:0]            in_action,
  input  logic [31:0]           in_net_address,
  input  logic [31:0]           in_net_mask,
  input  logic [31:0]           in_next_hop,
  input  logic [3:0]            in_iface_id,
  input  logic                  in_any_iface,
  input  logic [31:0]           in_dest_address,
  output logic [1:0]            out_status,
  output logic [31:0]           out_hop_address,
  output logic [3:0]            out_iface,
  output logic [2:0]            out_slot_index
);
  import rtlpm_pkg::*;

  localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ROUTE_SLOTS - 1);

  // request fields
  logic [1:0]  op_r;
  logic [31:0] net_r, mask_r, hop_r, dst_r;
  logic [3:0]  ifc_r;
  logic        any_r;

  logic [SLOT_W-1:0]      idx_r;
  logic [ROUTE_SLOTS-1:0] valid_r;

  // route storage, registered read
  route_entry_t mem [ROUTE_SLOTS];
  route_entry_t rd_r;
  logic              pv_r;
  logic [SLOT_W-1:0] pidx_r;

  // lookup best match
  logic              found_r;
  logic [31:0]       best_mask_r, best_hop_r;
  logic [3:0]        best_iface_r;
  logic [SLOT_W-1:0] best_idx_r;

  // add/delete result
  logic [1:0] st_r;
  logic [2:0] slot_r;

  logic ifc_ok;
  logic hit, better, del_hit;

  assign ifc_ok = ({28'd0, ifc_r} < 32'(IFACE_COUNT));

  assign sts.act      = op_r;
  assign sts.ifc_ok   = ifc_ok;
  assign sts.cur_free = !valid_r[idx_r];
  assign sts.last     = (idx_r == LAST_SLOT);

  // slot under evaluation is rd_r / pidx_r
  always_comb begin
    hit = pv_r && valid_r[pidx_r]
          && ((dst_r & rd_r.mask) == rd_r.net)
          && (any_r || (ifc_ok && (rd_r.iface == ifc_r)));
    better  = hit && (!found_r || (best_mask_r < rd_r.mask));
    del_hit = pv_r && (op_r == ACT_DEL) && valid_r[pidx_r]
              && (rd_r.iface == ifc_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      mem[idx_r] <= '{net: net_r, mask: mask_r, hop: hop_r, iface: ifc_r};
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      pv_r    <= 1'b0;
    end else begin
      pv_r <= cmd.scan;
      if (cmd.add_wr) begin
        valid_r[idx_r] <= 1'b1;
      end
      if (del_hit) begin
        valid_r[pidx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= idx_r;
    if (cmd.load) begin
      op_r    <= in_action;
      net_r   <= in_net_address;
      mask_r  <= in_net_mask;
      hop_r   <= in_next_hop;
      ifc_r   <= in_iface_id;
      any_r   <= in_any_iface;
      dst_r   <= in_dest_address;
      idx_r   <= '0;
      found_r <= 1'b0;
      st_r    <= ST_OK;
      slot_r  <= '0;
    end else if (cmd.step || cmd.scan) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.add_wr) begin
      slot_r <= 3'(idx_r);
    end
    if (cmd.add_full) begin
      st_r <= ST_FULL;
    end
    if ((op_r == ACT_LOOKUP) && better && !cmd.load) begin
      found_r      <= 1'b1;
      best_mask_r  <= rd_r.mask;
      best_hop_r   <= rd_r.hop;
      best_iface_r <= rd_r.iface;
      best_idx_r   <= pidx_r;
    end
  end

  always_comb begin
    out_status      = st_r;
    out_hop_address = '0;
    out_iface       = '0;
    out_slot_index  = slot_r;
    if (op_r == ACT_LOOKUP) begin
      if (found_r) begin
        out_status      = ST_OK;
        out_hop_address = best_hop_r;
        out_iface       = best_iface_r;
        out_slot_index  = 3'(best_idx_r);
      end else begin
        out_status     = ST_NOROUTE;
        out_slot_index = '0;
      end
    end
  end

  a_add_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_wr |-> !valid_r[idx_r])
    else $error("add overwrote a valid route");

  a_add_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_wr |=> valid_r[$past(idx_r)])
    else $error("added route not marked valid");

  a_lookup_keeps_table: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r && op_r == ACT_LOOKUP |=> valid_r == $past(valid_r))
    else $error("lookup changed table contents");

endmodule

[rtl/core/ipv4_route_table_lpm_top.sv]
`timescale 1ns / 1ps
// IPv4 route table, longest-prefix lookup, ROUTE_SLOTS routes.
// Request channel: in_* fields are taken at a rising edge with start high
// and busy low; busy stays high until the result has been shown.
// Requests: add (first free slot, or table full), delete all routes of an
// interface, lookup (longest mask wins, lower slot on a tie).
// Result channel: out_* fields are valid for exactly one cycle with
// out_valid high; the receiver cannot stall, it must take the result then.
// Steps from accept edge to result strobe, N = ROUTE_SLOTS:
//   lookup, delete: dispatch, all N slots read from the route RAM, one per
//     cycle, then pipeline drain and result
//   add: dispatch, valid bits searched one slot per cycle, then result
//   invalid interface on add/delete, unused code: dispatch, then result
// A new request is taken the cycle after the strobe; one request at a time.
// Reset (rst_n low, synchronous) clears all valid bits and returns the
// controller to idle; the route RAM itself is not cleared since
// invalid slots are never used.
module ipv4_route_table_lpm_top #(
  parameter int ROUTE_SLOTS = 8,
  parameter int IFACE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_net_address,
  input  logic [31:0] in_net_mask,
  input  logic [31:0] in_next_hop,
  input  logic [3:0]  in_iface_id,
  input  logic        in_any_iface,
  input  logic [31:0] in_dest_address,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_hop_address,
  output logic [3:0]  out_iface,
  output logic [2:0]  out_slot_index
);
  import rtlpm_pkg::*;

  rtlpm_cmd_t cmd;
  rtlpm_sts_t sts;

  // sequencing: dispatch, slot search/scan, drain, result
  rtlpm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .resp_valid (out_valid)
  );

  // request registers, route RAM, valid bits, match compare, best tracking
  rtlpm_dp #(
    .ROUTE_SLOTS (ROUTE_SLOTS),
    .IFACE_COUNT (IFACE_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_net_address  (in_net_address),
    .in_net_mask     (in_net_mask),
    .in_next_hop     (in_next_hop),
    .in_iface_id     (in_iface_id),
    .in_any_iface    (in_any_iface),
    .in_dest_address (in_dest_address),
    .out_status      (out_status),
    .out_hop_address (out_hop_address),
    .out_iface       (out_iface),
    .out_slot_index  (out_slot_index)
  );

endmodule
